// ----- hdl/fbfl_pkg.sv -----
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and constants of the fixed block free list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned MANAGE_BYTES = 24;
  localparam int unsigned ALIGN_BYTES  = 8;

  localparam int unsigned IDX_W   = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned PAY_W   = 13;
  localparam int unsigned BSIZE_W = 14;
  localparam int unsigned PROD_W  = IDX_W + BSIZE_W;
  localparam int unsigned OFF_W   = 18;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CFGI_W  = 1;

  localparam logic [CNT_W-1:0] COUNT_MAX     = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] MAX_BLOCKS_C  = CNT_W'(MAX_BLOCKS);
  localparam logic [PAY_W-1:0] PAYLOAD_RESET = PAY_W'(8);

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_REINIT = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [CFGI_W-1:0] {
    CFG_BLOCK_COUNT   = 1'b0,
    CFG_PAYLOAD_BYTES = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic accept;
    logic commit;
  } fbfl_cmd_t;

  typedef struct packed {
    logic out_free;
  } fbfl_stat_t;

endpackage

// ----- hdl/fbfl_ram.sv -----
// ----------------------------------------------------------------------------
// fbfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/fbfl_ctrl.sv -----
// ----------------------------------------------------------------------------
// fbfl_ctrl
// Two-state sequencer: take a beat, then commit it into the output register.
// ----------------------------------------------------------------------------
module fbfl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fbfl_pkg::fbfl_stat_t stat_i,
  output fbfl_pkg::fbfl_cmd_t  cmd_o
);
  import fbfl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.commit = stat_i.out_free;
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/fbfl_dp.sv -----
// ----------------------------------------------------------------------------
// fbfl_dp
// Free list datapath: head, count, link memory, offset and output register.
// ----------------------------------------------------------------------------
module fbfl_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fbfl_pkg::fbfl_cmd_t          cmd_i,
  output fbfl_pkg::fbfl_stat_t         stat_o,
  input  logic                         cfg_we_i,
  input  logic [fbfl_pkg::CFGI_W-1:0]  cfg_idx_i,
  input  logic [fbfl_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic [1:0]                   opcode_i,
  input  logic [fbfl_pkg::IDX_W-1:0]   block_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [fbfl_pkg::IDX_W-1:0]   granted_index_o,
  output logic [fbfl_pkg::OFF_W-1:0]   payload_offset_o,
  output logic [fbfl_pkg::CNT_W-1:0]   free_blocks_o
);
  import fbfl_pkg::*;

  logic [CNT_W-1:0]      block_count_q;
  logic [PAY_W-1:0]      payload_q;
  logic [CNT_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      total_q, total_d;
  logic [CNT_W-1:0]      pool_q, pool_d;
  logic [MAX_BLOCKS-1:0] vld_q, vld_d;
  op_e                   op_q;
  logic [IDX_W-1:0]      idx_q;

  logic                  out_valid_q;
  status_e               status_q, status_d;
  logic [IDX_W-1:0]      granted_q, granted_d;
  logic [OFF_W-1:0]      offset_q, offset_d;
  logic [CNT_W-1:0]      free_q;

  logic [CNT_W-1:0]      rd_link;
  logic [CNT_W-1:0]      link;
  logic                  mem_we;
  logic [BSIZE_W-1:0]    bsize_sum, bsize;
  logic [PROD_W-1:0]     prod;
  logic                  has_offset;
  logic [CNT_W-1:0]      clamp_cnt;

  fbfl_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (idx_q),
    .wdata_i (head_q),
    .re_i    (cmd_i.accept),
    .raddr_i (head_q[IDX_W-1:0]),
    .rdata_o (rd_link)
  );

  assign link = vld_q[head_q[IDX_W-1:0]] ? rd_link : head_q + CNT_W'(1);

  assign bsize_sum = BSIZE_W'(payload_q) + BSIZE_W'(HEADER_BYTES + ALIGN_BYTES - 1);
  assign bsize     = bsize_sum & ~BSIZE_W'(ALIGN_BYTES - 1);
  assign prod      = PROD_W'(granted_d) * PROD_W'(bsize);
  assign clamp_cnt = (block_count_q > MAX_BLOCKS_C) ? MAX_BLOCKS_C : block_count_q;

  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    head_d     = head_q;
    total_d    = total_q;
    pool_d     = pool_q;
    vld_d      = vld_q;
    mem_we     = 1'b0;
    status_d   = ST_OK;
    granted_d  = '0;
    has_offset = 1'b0;
    unique case (op_q)
      OP_ALLOC: begin
        if (total_q == '0 || head_q >= pool_q) begin
          status_d = ST_EMPTY;
        end else begin
          granted_d  = head_q[IDX_W-1:0];
          has_offset = 1'b1;
          head_d     = link;
          total_d    = total_q - CNT_W'(1);
        end
      end
      OP_FREE: begin
        granted_d = idx_q;
        if ({1'b0, idx_q} >= pool_q) begin
          status_d = ST_RANGE;
        end else begin
          has_offset   = 1'b1;
          mem_we       = cmd_i.commit;
          vld_d[idx_q] = 1'b1;
          head_d       = {1'b0, idx_q};
          if (total_q < COUNT_MAX) begin
            total_d = total_q + CNT_W'(1);
          end
        end
      end
      OP_REINIT: begin
        vld_d   = '0;
        pool_d  = clamp_cnt;
        head_d  = '0;
        total_d = clamp_cnt;
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
    offset_d = has_offset ? OFF_W'(prod + PROD_W'(MANAGE_BYTES + HEADER_BYTES)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= MAX_BLOCKS_C;
      payload_q     <= PAYLOAD_RESET;
      head_q        <= '0;
      total_q       <= MAX_BLOCKS_C;
      pool_q        <= MAX_BLOCKS_C;
      vld_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_BLOCK_COUNT:   block_count_q <= cfg_data_i[CNT_W-1:0];
          CFG_PAYLOAD_BYTES: payload_q     <= cfg_data_i[PAY_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.commit) begin
        head_q      <= head_d;
        total_q     <= total_d;
        pool_q      <= pool_d;
        vld_q       <= vld_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= op_e'(opcode_i);
      idx_q <= block_index_i;
    end
    if (cmd_i.commit) begin
      status_q  <= status_d;
      granted_q <= granted_d;
      offset_q  <= offset_d;
      free_q    <= total_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign granted_index_o  = granted_q;
  assign payload_offset_o = offset_q;
  assign free_blocks_o    = free_q;

endmodule

// ----- hdl/fixed_block_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Pool of equal-sized blocks tracked by a linked free list.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one beat of opcode_i and
// block_index_i (allocate, free, reinitialize, no operation). Output channel:
// out_valid_o / out_stall_i carry one result beat per input beat with
// status, block index, payload byte offset and the free block count.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 block
// count, 1 payload bytes); the user must write only while idle; not enforced.
// Sequencing: an accepted beat waits for the registered read of the link
// memory, then commits into the output register once it is free. The input
// stalls until that commit, so a new beat is not taken before the last.
// Reinitialize clears the per-entry valid bits at its commit, so it is
// sequenced like any other beat.
// Reset: the pool holds 64 free blocks in order, block count 64, payload
// 8 bytes; no result is pending.
// When the receiver stalls, the result holds in the output register and a
// following beat waits in the commit step until the register frees.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fbfl_pkg::CFGI_W-1:0] cfg_idx_i,
  input  logic [fbfl_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  opcode_i,
  input  logic [fbfl_pkg::IDX_W-1:0]  block_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [fbfl_pkg::IDX_W-1:0]  granted_index_o,
  output logic [fbfl_pkg::OFF_W-1:0]  payload_offset_o,
  output logic [fbfl_pkg::CNT_W-1:0]  free_blocks_o
);
  import fbfl_pkg::*;

  fbfl_cmd_t  cmd;
  fbfl_stat_t stat;

  fbfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fbfl_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (opcode_i),
    .block_index_i    (block_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .granted_index_o  (granted_index_o),
    .payload_offset_o (payload_offset_o),
    .free_blocks_o    (free_blocks_o)
  );

endmodule
